[rtl/tia_pkg.sv]
// ----------------------------------------------------------------------------
// tia_pkg
// Types, codes and helpers shared by the typed integer alu modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tia_pkg;

  // command codes
  localparam logic [3:0] CMD_NEG    = 4'd0;
  localparam logic [3:0] CMD_NOT    = 4'd1;
  localparam logic [3:0] CMD_BITNOT = 4'd2;
  localparam logic [3:0] CMD_ADD    = 4'd3;
  localparam logic [3:0] CMD_SUB    = 4'd4;
  localparam logic [3:0] CMD_MUL    = 4'd5;
  localparam logic [3:0] CMD_DIV    = 4'd6;
  localparam logic [3:0] CMD_MOD    = 4'd7;
  localparam logic [3:0] CMD_AND    = 4'd8;
  localparam logic [3:0] CMD_OR     = 4'd9;
  localparam logic [3:0] CMD_XOR    = 4'd10;
  localparam logic [3:0] CMD_SHL    = 4'd11;
  localparam logic [3:0] CMD_SHR    = 4'd12;

  // kind codes
  localparam logic [3:0] KIND_CINT   = 4'd0;
  localparam logic [3:0] KIND_BOOL   = 4'd1;
  localparam logic [3:0] KIND_CHAR   = 4'd2;
  localparam logic [3:0] KIND_UCHAR  = 4'd3;
  localparam logic [3:0] KIND_SHORT  = 4'd4;
  localparam logic [3:0] KIND_USHORT = 4'd5;
  localparam logic [3:0] KIND_INT    = 4'd6;
  localparam logic [3:0] KIND_UINT   = 4'd7;
  localparam logic [3:0] KIND_LONG   = 4'd8;
  localparam logic [3:0] KIND_ULONG  = 4'd9;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO  = 2'd1;
  localparam logic [1:0] ST_MIN_NEG1  = 2'd2;
  localparam logic [1:0] ST_SHIFT_OOR = 2'd3;

  localparam logic [63:0] SHIFT_COUNT_LIMIT = 64'h0000_0000_7fff_ffff;
  localparam int          DIV_STEPS         = 64;

  // control that travels with a transaction through the divider
  typedef struct packed {
    logic [3:0] cmd;
    logic [3:0] lk;
    logic       neg_q;
    logic       neg_r;
    logic [1:0] status;
    logic       bypass;
  } tia_ctrl_t;

  typedef struct packed {
    tia_ctrl_t   ctrl;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] dvs;
  } tia_stage_t;

  function automatic logic [6:0] kind_width(input logic [3:0] k);
    logic [6:0] w;
    unique case (k)
      KIND_CHAR, KIND_UCHAR:                     w = 7'd8;
      KIND_SHORT, KIND_USHORT:                   w = 7'd16;
      KIND_CINT, KIND_BOOL, KIND_INT, KIND_UINT: w = 7'd32;
      default:                                   w = 7'd64;
    endcase
    return w;
  endfunction

  function automatic logic kind_unsigned(input logic [3:0] k);
    logic u;
    unique case (k)
      KIND_CINT, KIND_BOOL, KIND_CHAR, KIND_SHORT, KIND_INT, KIND_LONG: u = 1'b0;
      default: u = 1'b1;
    endcase
    return u;
  endfunction

  // truncate raw bits to a kind: sign-extend signed, mask unsigned
  function automatic logic [63:0] fit_kind(input logic [63:0] v, input logic [3:0] k);
    logic        u;
    logic [63:0] r;
    u = kind_unsigned(k);
    unique case (kind_width(k))
      7'd8:    r = u ? {56'b0, v[7:0]} : {{56{v[7]}}, v[7:0]};
      7'd16:   r = u ? {48'b0, v[15:0]} : {{48{v[15]}}, v[15:0]};
      7'd32:   r = u ? {32'b0, v[31:0]} : {{32{v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/typed_integer_alu.sv]
// ----------------------------------------------------------------------------
// typed_integer_alu
// Typed 64-bit integer alu with truncation to the width of the left kind.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle when the output side keeps up; each result
// passes 68 register stages (three front stages, 64 divider stages with one
// quotient bit each, and the output register) before it is offered on the
// output. Every command travels the full depth, so results leave in order.
// A stall on the output holds the whole pipeline and is passed straight back
// to the input.
`default_nettype none

module typed_integer_alu import tia_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  command,
  input  wire logic [3:0]  left_kind,
  input  wire logic [63:0] left_value,
  input  wire logic [3:0]  right_kind,
  input  wire logic [63:0] right_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [63:0]      result_value
);

  logic       adv;
  logic       fr_valid, dv_valid;
  tia_stage_t fr_stage, dv_stage;

  // pipeline moves whenever the output register can take a value
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  tia_front u_front (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (in_valid),
    .command     (command),
    .left_kind   (left_kind),
    .left_value  (left_value),
    .right_kind  (right_kind),
    .right_value (right_value),
    .fr_valid    (fr_valid),
    .fr_stage    (fr_stage)
  );

  tia_divider u_divider (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .dv_in_valid  (fr_valid),
    .dv_in        (fr_stage),
    .dv_out_valid (dv_valid),
    .dv_out       (dv_stage)
  );

  // sign fixup, selection and truncation to the left kind
  logic [63:0] raw_r, final_r;
  always_comb begin
    raw_r = dv_stage.quo;
    if (dv_stage.ctrl.cmd == CMD_DIV) begin
      raw_r = dv_stage.ctrl.neg_q ? (64'd0 - dv_stage.quo) : dv_stage.quo;
    end else if (dv_stage.ctrl.cmd == CMD_MOD) begin
      raw_r = dv_stage.ctrl.neg_r ? (64'd0 - dv_stage.rem) : dv_stage.rem;
    end
    final_r = (dv_stage.ctrl.status != ST_OK) ? 64'd0 : fit_kind(raw_r, dv_stage.ctrl.lk);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid;
    end
    if (adv) begin
      status       <= dv_stage.ctrl.status;
      result_value <= final_r;
    end
  end

endmodule

`default_nettype wire

[rtl/tia_front.sv]
// ----------------------------------------------------------------------------
// tia_front
// Operand conversion, simple operations, multiply and divider setup.
// ----------------------------------------------------------------------------
`default_nettype none

module tia_front import tia_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        adv,
  input  wire logic        in_valid,
  input  wire logic [3:0]  command,
  input  wire logic [3:0]  left_kind,
  input  wire logic [63:0] left_value,
  input  wire logic [3:0]  right_kind,
  input  wire logic [63:0] right_value,
  output logic             fr_valid,
  output tia_stage_t       fr_stage
);

  // stage 0 registers
  logic        v0;
  logic [3:0]  cmd0, lk0;
  logic [63:0] a0, b0;
  logic [63:0] b_conv;
  logic        is_shift_in;

  // right operand conversion
  always_comb begin
    is_shift_in = (command == CMD_SHL) || (command == CMD_SHR);
    b_conv = right_value;
    if (!is_shift_in && (right_kind != left_kind)) begin
      if (left_kind == KIND_BOOL) begin
        b_conv = {63'b0, |right_value};
      end else begin
        b_conv = fit_kind(right_value, left_kind);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
    if (adv) begin
      cmd0 <= command;
      lk0  <= left_kind;
      a0   <= left_value;
      b0   <= b_conv;
    end
  end

  // stage 1: simple ops, status, divider magnitudes, partial products
  logic        uns0, na, nb, is_div0, shift_bad;
  logic [63:0] simple_r;
  logic [1:0]  status_c;
  logic [63:0] ma, mb;
  logic [5:0]  sh;

  always_comb begin
    uns0      = kind_unsigned(lk0);
    sh        = b0[5:0];
    shift_bad = (b0 > SHIFT_COUNT_LIMIT) || (b0 >= {57'b0, kind_width(lk0)});
    is_div0   = (cmd0 == CMD_DIV) || (cmd0 == CMD_MOD);
    na        = !uns0 && a0[63];
    nb        = !uns0 && b0[63];
    ma        = na ? (64'd0 - a0) : a0;
    mb        = nb ? (64'd0 - b0) : b0;
    simple_r  = 64'd0;
    status_c  = ST_OK;
    unique case (cmd0)
      CMD_NEG:    simple_r = 64'd0 - a0;
      CMD_NOT:    simple_r = {63'b0, (a0 == 64'd0)};
      CMD_BITNOT: simple_r = ~a0;
      CMD_ADD:    simple_r = a0 + b0;
      CMD_SUB:    simple_r = a0 - b0;
      CMD_AND:    simple_r = a0 & b0;
      CMD_OR:     simple_r = a0 | b0;
      CMD_XOR:    simple_r = a0 ^ b0;
      CMD_SHL: begin
        if (shift_bad) status_c = ST_SHIFT_OOR;
        simple_r = a0 << sh;
      end
      CMD_SHR: begin
        if (shift_bad) status_c = ST_SHIFT_OOR;
        simple_r = uns0 ? (a0 >> sh) : 64'($signed(a0) >>> sh);
      end
      CMD_DIV, CMD_MOD: begin
        if (b0 == 64'd0) begin
          status_c = ST_DIV_ZERO;
        end else if (!uns0 && (b0 == '1) && (a0 == 64'h8000_0000_0000_0000)) begin
          status_c = ST_MIN_NEG1;
        end
      end
      default: simple_r = 64'd0;
    endcase
  end

  logic        v1;
  tia_ctrl_t   ctrl1;
  logic [63:0] r1, ma1, mb1, p0;
  logic [31:0] p1, p2;
  logic        is_div1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
    if (adv) begin
      ctrl1.cmd    <= cmd0;
      ctrl1.lk     <= lk0;
      ctrl1.neg_q  <= na ^ nb;
      ctrl1.neg_r  <= na;
      ctrl1.status <= status_c;
      ctrl1.bypass <= !is_div0 || (status_c != ST_OK);
      is_div1      <= is_div0;
      r1           <= simple_r;
      ma1          <= ma;
      mb1          <= mb;
      p0           <= {32'b0, a0[31:0]} * {32'b0, b0[31:0]};
      p1           <= a0[31:0] * b0[63:32];
      p2           <= a0[63:32] * b0[31:0];
    end
  end

  // stage 2: multiply combine, load divider
  logic [63:0] mul_r;
  assign mul_r = p0 + {p1 + p2, 32'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (adv) begin
      fr_valid <= v1;
    end
    if (adv) begin
      fr_stage.ctrl <= ctrl1;
      fr_stage.rem  <= 64'd0;
      fr_stage.dvs  <= mb1;
      fr_stage.quo  <= is_div1 ? ma1 : ((ctrl1.cmd == CMD_MUL) ? mul_r : r1);
    end
  end

endmodule

`default_nettype wire

[rtl/tia_divider.sv]
// ----------------------------------------------------------------------------
// tia_divider
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tia_divider import tia_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       adv,
  input  wire logic       dv_in_valid,
  input  wire tia_stage_t dv_in,
  output logic            dv_out_valid,
  output tia_stage_t      dv_out
);

  logic       vld [DIV_STEPS];
  tia_stage_t stg [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    tia_stage_t  src;
    logic        src_v;
    logic [64:0] trial;
    logic [64:0] shifted;

    if (k == 0) begin : g_first
      assign src   = dv_in;
      assign src_v = dv_in_valid;
    end else begin : g_next
      assign src   = stg[k-1];
      assign src_v = vld[k-1];
    end

    // trial subtract of the shifted partial remainder
    assign shifted = {src.rem, src.quo[63]};
    assign trial   = shifted - {1'b0, src.dvs};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= src_v;
      end
      if (adv) begin
        stg[k].ctrl <= src.ctrl;
        stg[k].dvs  <= src.dvs;
        if (src.ctrl.bypass) begin
          stg[k].rem <= src.rem;
          stg[k].quo <= src.quo;
        end else if (!trial[64]) begin
          stg[k].rem <= trial[63:0];
          stg[k].quo <= {src.quo[62:0], 1'b1};
        end else begin
          stg[k].rem <= shifted[63:0];
          stg[k].quo <= {src.quo[62:0], 1'b0};
        end
      end
    end
  end

  assign dv_out_valid = vld[DIV_STEPS-1];
  assign dv_out       = stg[DIV_STEPS-1];

endmodule

`default_nettype wire
